// ===== rtl/core/six_step_fft_assert.svh =====
// Assertion macros for the six-step FFT RTL (used by the datapath).
// No dependencies; included by modules that assert.
`ifndef SIX_STEP_FFT_ASSERT_SVH
`define SIX_STEP_FFT_ASSERT_SVH

// Implication checked every clock, off while in reset.
`define SSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ssfft_pkg.sv =====
// Package for the six-step FFT: sizes, twiddle ROM, command/state types.
// No dependencies.
package ssfft_pkg;
    localparam int POINTS = 64;
    localparam int SIDE = 8;
    localparam int AW = $clog2(POINTS);
    localparam int SW = $clog2(SIDE);
    localparam int QUARTER = POINTS / 4;
    localparam int DW = 24;

    typedef enum logic [2:0] {
        ST_LOAD, ST_TR1, ST_FFT1, ST_TR2, ST_TWID, ST_FFT2, ST_TR3, ST_EMIT
    } ssf_state_t;

    // One datapath operation: read pa/pb, compute, write back.
    typedef enum logic [1:0] {
        OP_SWAP, OP_BFLY, OP_MUL
    } ssf_op_t;

    typedef struct packed {
        logic          go;
        ssf_op_t       op;
        logic [AW-1:0] pa;
        logic [AW-1:0] pb;
        logic [AW-1:0] tw;
    } ssf_cmd_t;

    // Quarter-wave sine, Q1.15, +1 held as 32767.
    function automatic logic [15:0] qsine(input logic [$clog2(QUARTER+1)-1:0] k);
        logic [15:0] v;
        case (k)
            5'd0: v = 16'd0;      5'd1: v = 16'd3212;   5'd2: v = 16'd6393;
            5'd3: v = 16'd9512;   5'd4: v = 16'd12540;  5'd5: v = 16'd15447;
            5'd6: v = 16'd18205;  5'd7: v = 16'd20788;  5'd8: v = 16'd23170;
            5'd9: v = 16'd25330;  5'd10: v = 16'd27246; 5'd11: v = 16'd28899;
            5'd12: v = 16'd30274; 5'd13: v = 16'd31357; 5'd14: v = 16'd32138;
            5'd15: v = 16'd32610; default: v = 16'd32767;
        endcase
        return v;
    endfunction

    // Bit reversal of an index within a row.
    function automatic logic [SW-1:0] brev(input logic [SW-1:0] x);
        logic [SW-1:0] r;
        for (int i = 0; i < SW; i++) r[i] = x[SW-1-i];
        return r;
    endfunction
endpackage

// ===== rtl/core/six_step_fft.sv =====
// Six-step 64-point radix-2 FFT; one shared butterfly, one work memory.
// Operation: 64 loads, then the swap/butterfly/twiddle ops and the skipped
// bit-reversal slots, then 64 bins at one per cycle while m_ready is held.
// All compute runs on the single six-phase datapath op sequence; no load
// overlaps compute or emit.
// Synchronous active-low reset returns to frame load with count zero.
module six_step_fft import ssfft_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_sample_real,
    input  logic signed [15:0]   s_sample_imag,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [DW-1:0] m_bin_real,
    output logic signed [DW-1:0] m_bin_imag,
    output logic [5:0]           m_bin_number,
    output logic                 m_frame_end
);
    ssf_cmd_t      cmd;
    logic          dp_busy, load_en, load_ready, emit_en, in_fire, out_fire;
    logic [AW-1:0] load_addr, emit_addr, emit_next;
    logic          ov_reg;       // output word valid
    logic [AW-1:0] on_reg;       // bin held in output register
    logic          rdv_reg;      // read data belongs to emit_addr

    // Accept samples only while loading.
    assign in_fire = s_valid && s_ready;
    // Emit counter advances when the held word is taken.
    assign out_fire = m_valid && m_ready;

    ssfft_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_fire, .dp_busy,
        .load_en, .load_ready, .load_addr, .cmd, .emit_en, .emit_addr
    );

    // Read the memory one bin ahead so data is ready after a take.
    assign emit_next = out_fire ? emit_addr + AW'(1) : emit_addr;

    ssfft_dp u_dp (
        .aclk, .aresetn, .load_en, .load_addr,
        .load_re(s_sample_real), .load_im(s_sample_imag),
        .cmd, .busy(dp_busy), .rd_addr(emit_next),
        .rd_re(m_bin_real), .rd_im(m_bin_imag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            // Valid is registered from the emit enable and held across the frame.
            rdv_reg <= emit_en && !(out_fire && emit_addr == AW'(POINTS-1));
            ov_reg <= emit_en && !(out_fire && emit_addr == AW'(POINTS-1));
        end
        on_reg <= emit_next;
    end

    assign s_ready = !emit_en && !ov_reg && cmd == '0 && !dp_busy
                     && (load_addr != '0 || !rdv_reg) && load_ready;
    assign m_valid = ov_reg && rdv_reg;
    assign m_bin_number = on_reg[5:0];
    assign m_frame_end = m_valid && on_reg == AW'(POINTS-1);
endmodule

// ===== rtl/core/ssfft_ctrl.sv =====
// Sequencer of the six-step FFT: load, transposes, row FFTs, twiddle, emit.
// Depends on ssfft_pkg.
module ssfft_ctrl import ssfft_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          out_fire,
    input  logic          dp_busy,
    output logic          load_en,
    output logic          load_ready,
    output logic [AW-1:0] load_addr,
    output ssf_cmd_t      cmd,
    output logic          emit_en,
    output logic [AW-1:0] emit_addr
);
    ssf_state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;   // load count / emit index
    logic [SW-1:0] a_reg, b_reg;        // transpose / row pointers
    logic [SW-1:0] row_reg;
    logic [SW-1:0] s_reg;               // stage, one-hot half length
    logic [SW-1:0] g_reg, k_reg;
    logic          phase_reg;           // 0 bit reverse, 1 butterflies
    logic          last_op;
    logic [SW-1:0] half;
    logic [SW-1:0] tw_k;                // k * SIDE / len

    assign half = s_reg;

    // Scale k by SIDE/len: shift by the distance of the stage bit from the top.
    always_comb begin
        tw_k = '0;
        for (int i = 0; i < SW; i++)
            if (s_reg[i]) tw_k = k_reg << (SW - 1 - i);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (in_fire && cnt_reg == AW'(POINTS-1)) state_next = ST_TR1;
            ST_TR1:  if (!dp_busy && last_op) state_next = ST_FFT1;
            ST_FFT1: if (!dp_busy && last_op) state_next = ST_TR2;
            ST_TR2:  if (!dp_busy && last_op) state_next = ST_TWID;
            ST_TWID: if (!dp_busy && last_op) state_next = ST_FFT2;
            ST_FFT2: if (!dp_busy && last_op) state_next = ST_TR3;
            ST_TR3:  if (!dp_busy && last_op) state_next = ST_EMIT;
            ST_EMIT: if (out_fire && cnt_reg == AW'(POINTS-1)) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // Last operation of the current sweep.
    always_comb begin
        unique case (state_reg)
            ST_TR1, ST_TR2, ST_TR3:
                last_op = (a_reg == SW'(SIDE-2)) && (b_reg == SW'(SIDE-1));
            ST_TWID: last_op = (a_reg == SW'(SIDE-1)) && (b_reg == SW'(SIDE-1));
            ST_FFT1, ST_FFT2:
                last_op = phase_reg && row_reg == SW'(SIDE-1) && s_reg[SW-1]
                          && k_reg == SW'(SIDE/2-1);
            default: last_op = 1'b0;
        endcase
    end

    always_comb begin
        cmd = '0;
        load_en = (state_reg == ST_LOAD) && in_fire;
        load_ready = (state_reg == ST_LOAD);
        load_addr = cnt_reg;
        // Hold off the emit until the last transpose swap has been written.
        emit_en = (state_reg == ST_EMIT) && !dp_busy;
        emit_addr = cnt_reg;
        unique case (state_reg)
            ST_TR1, ST_TR2, ST_TR3: begin
                cmd.go = !dp_busy;
                cmd.op = OP_SWAP;
                cmd.pa = {a_reg, b_reg};
                cmd.pb = {b_reg, a_reg};
            end
            ST_TWID: begin
                cmd.go = !dp_busy;
                cmd.op = OP_MUL;
                cmd.pa = {a_reg, b_reg};
                cmd.pb = {a_reg, b_reg};
                cmd.tw = AW'(a_reg) * AW'(b_reg);
            end
            ST_FFT1, ST_FFT2: begin
                cmd.go = !dp_busy && (phase_reg || (b_reg < brev(b_reg)));
                cmd.op = phase_reg ? OP_BFLY : OP_SWAP;
                if (phase_reg) begin
                    cmd.pa = {row_reg, g_reg + k_reg};
                    cmd.pb = {row_reg, g_reg + k_reg + half};
                    // twiddle index k * (SIDE/len) * SIDE
                    cmd.tw = {tw_k, SW'(0)};
                end else begin
                    cmd.pa = {row_reg, b_reg};
                    cmd.pb = {row_reg, brev(b_reg)};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if ((state_reg == ST_LOAD && in_fire) || (state_reg == ST_EMIT && out_fire))
            cnt_next = cnt_reg + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            a_reg <= '0; b_reg <= '0; row_reg <= '0;
            s_reg <= SW'(1); g_reg <= '0; k_reg <= '0; phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_next != state_reg) begin
                a_reg <= '0;
                b_reg <= (state_next == ST_TWID || state_next == ST_FFT1
                          || state_next == ST_FFT2) ? SW'(0) : SW'(1);
                row_reg <= '0; s_reg <= SW'(1); g_reg <= '0; k_reg <= '0;
                phase_reg <= 1'b0;
            end else if (!dp_busy) begin
                unique case (state_reg)
                    ST_TR1, ST_TR2, ST_TR3: begin
                        if (b_reg == SW'(SIDE-1)) begin
                            a_reg <= a_reg + SW'(1);
                            b_reg <= a_reg + SW'(2);
                        end else b_reg <= b_reg + SW'(1);
                    end
                    ST_TWID: begin
                        b_reg <= b_reg + SW'(1);
                        if (b_reg == SW'(SIDE-1)) a_reg <= a_reg + SW'(1);
                    end
                    ST_FFT1, ST_FFT2: begin
                        if (!phase_reg) begin
                            b_reg <= b_reg + SW'(1);
                            if (b_reg == SW'(SIDE-1)) phase_reg <= 1'b1;
                        end else if (k_reg == half - SW'(1)) begin
                            k_reg <= '0;
                            if ({1'b0, g_reg} + {1'b0, half, 1'b0} >= (SW+1)'(SIDE)) begin
                                g_reg <= '0;
                                if (s_reg[SW-1]) begin
                                    s_reg <= SW'(1);
                                    phase_reg <= 1'b0;
                                    b_reg <= '0;
                                    row_reg <= row_reg + SW'(1);
                                end else s_reg <= s_reg << 1;
                            end else g_reg <= g_reg + (half << 1);
                        end else k_reg <= k_reg + SW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/core/ssfft_dp.sv =====
// Datapath: work memory, complex multiplier, butterfly and saturation.
// Depends on ssfft_pkg and the assertion header.
`include "six_step_fft_assert.svh"
module ssfft_dp import ssfft_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_en,
    input  logic [AW-1:0]        load_addr,
    input  logic signed [15:0]   load_re,
    input  logic signed [15:0]   load_im,
    input  ssf_cmd_t             cmd,
    output logic                 busy,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [DW-1:0] rd_re,
    output logic signed [DW-1:0] rd_im
);
    logic signed [DW-1:0] mem_re [POINTS];
    logic signed [DW-1:0] mem_im [POINTS];

    // Phases: 0 read a, 1 read b, 2 multiply, 3 round and saturate, 4 write a, 5 write b.
    logic [2:0] ph_reg;
    ssf_cmd_t   c_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [DW-1:0] rr_reg, ri_reg;
    logic signed [DW+17:0] pr_reg, pi_reg;
    logic signed [16:0] wr, wi;
    logic signed [15:0] cs, sn;
    logic [AW-3:0] r;
    logic [AW-1:0] tw;
    logic signed [DW+17:0] tr, ti;
    logic [AW-1:0] raddr;

    assign busy = (ph_reg != 3'd0);

    assign tw = c_reg.tw;
    assign r = tw[AW-3:0];
    always_comb begin
        logic [15:0] s0, s1;
        s0 = qsine({1'b0, r});
        s1 = qsine(($clog2(QUARTER+1))'(QUARTER) - {1'b0, r});
        case (tw[AW-1:AW-2])
            2'd0: begin cs = s1; sn = s0; end
            2'd1: begin cs = -s0; sn = s1; end
            2'd2: begin cs = -s1; sn = -s0; end
            default: begin cs = s0; sn = -s1; end
        endcase
        wr = 17'(cs);
        wi = -17'(sn);
    end

    // Round half up: floor((v + 2^14) / 2^15).
    assign tr = (pr_reg + (DW+18)'(16384)) >>> 15;
    assign ti = (pi_reg + (DW+18)'(16384)) >>> 15;

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+17:0] v);
        if (v > (DW+18)'(2**(DW-1)-1)) return {1'b0, {(DW-1){1'b1}}};
        if (v < -(DW+18)'(2**(DW-1))) return {1'b1, {(DW-1){1'b0}}};
        return v[DW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= 3'd0;
        end else begin
            unique case (ph_reg)
                3'd0: if (cmd.go) ph_reg <= 3'd1;
                3'd1: ph_reg <= 3'd2;
                3'd2: ph_reg <= 3'd3;
                3'd3: ph_reg <= 3'd4;
                3'd4: ph_reg <= 3'd5;
                default: ph_reg <= 3'd0;
            endcase
        end
    end

    assign raddr = (ph_reg == 3'd0) ? cmd.pa : c_reg.pb;

    always_ff @(posedge aclk) begin
        if (ph_reg == 3'd0 && cmd.go) c_reg <= cmd;
        rd_re <= mem_re[(ph_reg == 3'd0 && !cmd.go) ? rd_addr : raddr];
        rd_im <= mem_im[(ph_reg == 3'd0 && !cmd.go) ? rd_addr : raddr];
        if (ph_reg == 3'd1) begin ar_reg <= rd_re; ai_reg <= rd_im; end
        if (ph_reg == 3'd2) begin
            br_reg <= rd_re; bi_reg <= rd_im;
            pr_reg <= (DW+18)'(rd_re * wr) - (DW+18)'(rd_im * wi);
            pi_reg <= (DW+18)'(rd_re * wi) + (DW+18)'(rd_im * wr);
        end
        if (ph_reg == 3'd3) begin
            rr_reg <= sat(tr); ri_reg <= sat(ti);
        end
        if (load_en) begin
            mem_re[load_addr] <= DW'(load_re);
            mem_im[load_addr] <= DW'(load_im);
        end else if (ph_reg == 3'd4) begin
            unique case (c_reg.op)
                OP_SWAP: begin mem_re[c_reg.pa] <= br_reg; mem_im[c_reg.pa] <= bi_reg; end
                OP_MUL:  begin mem_re[c_reg.pa] <= rr_reg; mem_im[c_reg.pa] <= ri_reg; end
                default: begin
                    mem_re[c_reg.pa] <= sat((DW+18)'(ar_reg) + (DW+18)'(rr_reg));
                    mem_im[c_reg.pa] <= sat((DW+18)'(ai_reg) + (DW+18)'(ri_reg));
                end
            endcase
        end else if (ph_reg == 3'd5) begin
            unique case (c_reg.op)
                OP_SWAP: begin mem_re[c_reg.pb] <= ar_reg; mem_im[c_reg.pb] <= ai_reg; end
                OP_MUL:  ;
                default: begin
                    mem_re[c_reg.pb] <= sat((DW+18)'(ar_reg) - (DW+18)'(rr_reg));
                    mem_im[c_reg.pb] <= sat((DW+18)'(ai_reg) - (DW+18)'(ri_reg));
                end
            endcase
        end
    end

    `SSF_ASSERT_IMPL(a_no_load_busy, aclk, aresetn, load_en, ph_reg == 3'd0)
    `SSF_ASSERT_NEXT(a_go_starts, aclk, aresetn, ph_reg == 3'd0 && cmd.go, ph_reg == 3'd1)
    `SSF_ASSERT_NEXT(a_ph_end, aclk, aresetn, ph_reg == 3'd5, ph_reg == 3'd0)
endmodule

// ===== sim/six_step_fft_test.sv =====
// Self-checking testbench for the six-step 64-point FFT: drives complex
// samples, predicts every frame of bins and checks each one as it leaves.
// Depends on ssfft_pkg and the six_step_fft RTL.
module six_step_fft_test import ssfft_pkg::*;;

    // Integer predictor of the frame transform plus the queue of bins still owed.
    class fft_scoreboard;
        longint     work_re[POINTS];
        longint     work_im[POINTS];
        longint     qsin[QUARTER+1];
        int         fill;
        int         errors;
        longint     owed_re[$];
        longint     owed_im[$];
        int         owed_num[$];
        bit         owed_end[$];

        function new();
            longint unsigned x, x2, term;
            longint sum, r;
            fill = 0;
            errors = 0;
            // Quarter-wave sine by a truncated series in Q30, rounded to Q15.
            for (int k = 0; k <= QUARTER; k++) begin
                x = (64'd1686629713 * k) / QUARTER;
                x2 = (x * x) >> 30;
                term = x;
                sum = longint'(x);
                for (int n = 1; n <= 8; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2) sum -= longint'(term);
                    else sum += longint'(term);
                end
                if (sum < 0) r = 0;
                else r = (sum + 16384) >>> 15;
                qsin[k] = (r > 32767) ? 32767 : r;
            end
        endfunction

        function void twiddle(int m, output longint wr, output longint wi);
            int q, r;
            longint c, s;
            m = m & (POINTS - 1);
            q = m / QUARTER;
            r = m % QUARTER;
            case (q)
                0: begin c = qsin[QUARTER-r]; s = qsin[r]; end
                1: begin c = -qsin[r]; s = qsin[QUARTER-r]; end
                2: begin c = -qsin[QUARTER-r]; s = -qsin[r]; end
                default: begin c = qsin[r]; s = -qsin[QUARTER-r]; end
            endcase
            wr = c;
            wi = -s;
        endfunction

        function longint rnd_q15(longint v);
            return (v + 16384) >>> 15;
        endfunction

        function longint clip24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void swap_pair(int i, int j);
            longint t;
            t = work_re[i]; work_re[i] = work_re[j]; work_re[j] = t;
            t = work_im[i]; work_im[i] = work_im[j]; work_im[j] = t;
        endfunction

        function void transpose_grid();
            for (int a = 0; a < SIDE; a++)
                for (int b = a + 1; b < SIDE; b++) swap_pair(a * SIDE + b, b * SIDE + a);
        endfunction

        function void row_transform(int base);
            int j, bit_w, half, stride, pa, pb;
            longint wr, wi, ar, ai, br, bi, tr, ti;
            j = 0;
            for (int i = 1; i < SIDE; i++) begin
                bit_w = SIDE >> 1;
                while (bit_w != 0 && (j & bit_w)) begin
                    j ^= bit_w;
                    bit_w >>= 1;
                end
                j ^= bit_w;
                if (i < j) swap_pair(base + i, base + j);
            end
            for (int len = 2; len <= SIDE; len <<= 1) begin
                half = len / 2;
                stride = SIDE / len;
                for (int g = 0; g < SIDE; g += len)
                    for (int k = 0; k < half; k++) begin
                        pa = base + g + k;
                        pb = pa + half;
                        twiddle(k * stride * SIDE, wr, wi);
                        br = work_re[pb]; bi = work_im[pb];
                        ar = work_re[pa]; ai = work_im[pa];
                        tr = rnd_q15(br * wr - bi * wi);
                        ti = rnd_q15(br * wi + bi * wr);
                        work_re[pb] = clip24(ar - tr); work_im[pb] = clip24(ai - ti);
                        work_re[pa] = clip24(ar + tr); work_im[pa] = clip24(ai + ti);
                    end
            end
        endfunction

        function void transform_frame();
            longint wr, wi, xr, xi;
            int p;
            transpose_grid();
            for (int a = 0; a < SIDE; a++) row_transform(a * SIDE);
            transpose_grid();
            for (int a = 0; a < SIDE; a++)
                for (int b = 0; b < SIDE; b++) begin
                    p = a * SIDE + b;
                    xr = work_re[p]; xi = work_im[p];
                    twiddle(a * b, wr, wi);
                    work_re[p] = clip24(rnd_q15(xr * wr - xi * wi));
                    work_im[p] = clip24(rnd_q15(xr * wi + xi * wr));
                end
            for (int a = 0; a < SIDE; a++) row_transform(a * SIDE);
            transpose_grid();
        endfunction

        // Store one accepted sample; a full frame queues all its bins.
        function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
            work_re[fill] = re;
            work_im[fill] = im;
            fill++;
            if (fill == POINTS) begin
                fill = 0;
                transform_frame();
                for (int k = 0; k < POINTS; k++) begin
                    owed_re.push_back(work_re[k]);
                    owed_im.push_back(work_im[k]);
                    owed_num.push_back(k & 63);
                    owed_end.push_back(k == POINTS - 1);
                end
            end
        endfunction

        function void check_bin(logic signed [DW-1:0] re, logic signed [DW-1:0] im,
                                logic [5:0] num, logic fend);
            longint er, ei;
            int en;
            bit ee;
            if (owed_re.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected bin %0d: %0d %0d", num, re, im);
                return;
            end
            er = owed_re.pop_front();
            ei = owed_im.pop_front();
            en = owed_num.pop_front();
            ee = owed_end.pop_front();
            if (longint'(re) != er || longint'(im) != ei || int'(num) != en || fend != ee) begin
                errors++;
                if (errors <= 10)
                    $display("bin mismatch: exp %0d (%0d,%0d) end %0d, got %0d (%0d,%0d) end %0d",
                             en, er, ei, ee, num, re, im, fend);
            end
        endfunction

        function int pending();
            return owed_re.size();
        endfunction
    endclass

    localparam int RAND_WORDS = 488;
    localparam int QUIET_FROM = 440;
    localparam int CYCLE_LIMIT = 300000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [15:0]   s_sample_real;
    logic signed [15:0]   s_sample_imag;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [DW-1:0] m_bin_real;
    logic signed [DW-1:0] m_bin_imag;
    logic [5:0]           m_bin_number;
    logic                 m_frame_end;

    fft_scoreboard spectrum = new();
    bit            quiet;
    int            cycles;
    int            ready_hold;

    six_step_fft DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_real (s_sample_real),
        .s_sample_imag (s_sample_imag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_real    (m_bin_real),
        .m_bin_imag    (m_bin_imag),
        .m_bin_number  (m_bin_number),
        .m_frame_end   (m_frame_end)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: stop a hung run well past the slowest legal schedule.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: drop ready in random bursts, hold it high when quiet.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                ready_hold = $urandom_range(0, 3);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check every bin word that leaves the block.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            spectrum.check_bin(m_bin_real, m_bin_imag, m_bin_number, m_frame_end);
    end

    // Present one sample word, maybe after a gap, and hold it until taken.
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_real = re;
        s_sample_imag = im;
        do @(posedge aclk); while (!s_ready);
        spectrum.note_sample(re, im);
    endtask

    // Random sample: full range most of the time, else small values or rails.
    task automatic send_random();
        logic signed [15:0] re, im;
        case ($urandom_range(0, 5))
            0: begin
                re = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                im = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            end
            1: begin
                re = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                im = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
                re = 16'($urandom);
                im = 16'($urandom);
            end
        endcase
        send_sample(re, im);
    endtask

    initial begin
        quiet = 1'b0;
        cycles = 0;
        ready_hold = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample_real = '0;
        s_sample_imag = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed head of the first frame: rails, zero, alternating bits, one LSB, runs of rails and zeros.
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh5555, 16'shAAAA);
        send_sample(16'shAAAA, 16'sh5555);
        send_sample(16'sh0001, 16'shFFFF);
        for (int i = 0; i < 8; i++) send_sample(16'sh7FFF, 16'sh8000);
        for (int i = 0; i < 8; i++) send_sample(16'sh0000, 16'sh0000);

        // Random frames; the tail runs without idling on either side.
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i == QUIET_FROM) quiet = 1'b1;
            send_random();
        end
        @(negedge aclk);
        s_valid = 1'b0;

        while (spectrum.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (spectrum.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ssfft_pkg.sv
rtl/core/ssfft_ctrl.sv
rtl/core/ssfft_dp.sv
rtl/core/six_step_fft.sv
sim/six_step_fft_test.sv
